// File: hdl/led_matrix_shadow_ram_writer_core_macros.svh
// Assertion macros shared by the LED matrix shadow RAM writer.
`ifndef LED_MATRIX_SHADOW_RAM_WRITER_CORE_MACROS_SVH
`define LED_MATRIX_SHADOW_RAM_WRITER_CORE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define LMSRW_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define LMSRW_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: hdl/lmsrw_pkg.sv
// Shared types and constants of the LED matrix shadow RAM writer.
package lmsrw_pkg;

	localparam int STORE_DEPTH         = 64;
	localparam int ADDR_W              = 6;
	localparam int NIB_W               = 4;
	localparam int MATRIX_COLS_DEFAULT = 32;

	localparam logic [1:0] CMD_SET   = 2'd0;
	localparam logic [1:0] CMD_GET   = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_SEND  = 2'd3;

	// Requests from the sequencer to the shadow store.
	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [NIB_W-1:0]  wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              clr;
	} store_req_t;

endpackage

// File: hdl/lmsrw_store.sv
// Shadow nibble store: one write port, one registered read port, per-entry valid bits.
module lmsrw_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lmsrw_pkg::store_req_t         req,
	output logic [lmsrw_pkg::NIB_W-1:0]   rd_data
);

	logic [lmsrw_pkg::NIB_W-1:0]       mem [lmsrw_pkg::STORE_DEPTH];
	logic [lmsrw_pkg::STORE_DEPTH-1:0] valid_q;
	logic [lmsrw_pkg::NIB_W-1:0]       rd_raw_q;
	logic                              rd_valid_q;

	// An entry not written since reset or the last clear reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.clr) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_raw_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_valid_q ? rd_raw_q : '0;

endmodule

// File: hdl/led_matrix_shadow_ram_writer_core.sv
// LED matrix shadow RAM writer: top level with command sequencer and output register.
//
// This block keeps a shadow copy of the nibble RAM of a serial LED matrix
// controller, 8 rows by MATRIX_COLS columns, and turns LED commands into the
// nibble write items that a downstream shifter serialises behind the write ID
// and start address. A command arrives as one item: tuser carries the command
// (set, get, clear and send screen, send screen) and tdata the column, row and
// new LED value. A set updates one bit and emits one write item with its
// address and new nibble; a get returns one answer item carrying the LED bit;
// clear zeroes the store and then, like send screen, streams every active
// nibble from address 0, frame_start marking the first item and tlast the
// final one. The active depth is twice MATRIX_COLS, capped at 64 entries. A
// set or get whose position lies beyond the active depth leaves the store
// alone: the set gives no item, the get answers with the LED bit at zero.
// The store is a synchronous memory with one write port and one registered
// read port; per-entry valid bits make it read as zero after reset or a
// clear, so no clearing pass is needed and a command can be accepted as soon
// as reset is released. A set or get is accepted with the memory read, then
// does the read-modify-write and the load of the result register. A screen
// dump reads each entry and then loads it into the result register, nibble
// by nibble. A new command is taken once the previous one is done, having
// loaded its last result if it gives one, even while that result still
// waits in the output register; downstream stalls hold the sequencer only
// when the next result is ready to be loaded.
`include "led_matrix_shadow_ram_writer_core_macros.svh"

module led_matrix_shadow_ram_writer_core #(
	parameter int MATRIX_COLS = lmsrw_pkg::MATRIX_COLS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// Command side.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // col [4:0], row [7:5], led_on [8], zeros [15:9]
	input  logic [1:0]  s_tuser,  // command [1:0]
	// Result side.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // nibble_addr [5:0], nibble_data [9:6], led_state [10],
	                              // zeros [15:11]
	output logic [1:0]  m_tuser,  // is_write [0], frame_start [1]
	output logic        m_tlast
);

	localparam int AW = lmsrw_pkg::ADDR_W;
	localparam int NW = lmsrw_pkg::NIB_W;

	// Active store depth, held one bit wider than an address so 64 fits.
	localparam int DEPTH_I = (2 * MATRIX_COLS > lmsrw_pkg::STORE_DEPTH) ?
	                         lmsrw_pkg::STORE_DEPTH : 2 * MATRIX_COLS;
	localparam logic [AW:0] DEPTH     = (AW+1)'(DEPTH_I);
	localparam logic [AW:0] LAST_ADDR = (AW+1)'(DEPTH_I - 1);

	// Sequencer states.
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EXEC  = 2'd1;
	localparam logic [1:0] ST_SREAD = 2'd2;
	localparam logic [1:0] ST_SOUT  = 2'd3;

	logic [1:0]    state_q, state_n;
	logic [1:0]    cmd_q;
	logic [AW-1:0] addr_q;
	logic [1:0]    col_lo_q;
	logic          on_q;
	logic          inside_q;
	logic [AW-1:0] idx_q, idx_n;

	// Output register.
	logic          m_tvalid_q;
	logic [AW-1:0] out_addr_q;
	logic [NW-1:0] out_data_q;
	logic          out_led_q;
	logic          out_wr_q;
	logic          out_fs_q;
	logic          out_last_q;

	logic                  in_acc;
	logic                  out_free;
	logic                  out_load;
	logic [AW-1:0]         in_addr;
	logic                  in_inside;
	logic [NW-1:0]         rd_data;
	logic [NW-1:0]         mask;
	logic [NW-1:0]         new_nib;
	logic                  stream_last;
	lmsrw_pkg::store_req_t req;

	// Load fields of the next result.
	logic          ld_wr, ld_fs, ld_led, ld_last;
	logic [AW-1:0] ld_addr;
	logic [NW-1:0] ld_data;

	// Nibble address: column bits 4:3 pick the 16-entry block, the row the
	// entry pair and column bit 2 the odd entry.
	assign in_addr   = {s_tdata[4:3], s_tdata[7:5], s_tdata[2]};
	assign in_inside = ({1'b0, in_addr} < DEPTH);

	assign s_tready    = (state_q == ST_IDLE);
	assign in_acc      = s_tvalid && s_tready;
	assign out_free    = !m_tvalid_q || m_tready;
	assign mask        = 4'b1000 >> col_lo_q;
	assign new_nib     = on_q ? (rd_data | mask) : (rd_data & ~mask);
	assign stream_last = ({1'b0, idx_q} == LAST_ADDR);

	lmsrw_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

	always_comb begin
		state_n     = state_q;
		idx_n       = idx_q;
		req         = '0;
		out_load    = 1'b0;
		ld_wr       = 1'b0;
		ld_fs       = 1'b0;
		ld_led      = 1'b0;
		ld_last     = 1'b0;
		ld_addr     = addr_q;
		ld_data     = '0;
		req.wr_addr = addr_q;
		req.wr_data = new_nib;
		req.rd_addr = in_addr;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (s_tuser)
						lmsrw_pkg::CMD_SET, lmsrw_pkg::CMD_GET: begin
							req.rd_en = 1'b1;
							state_n   = ST_EXEC;
						end
						lmsrw_pkg::CMD_CLEAR: begin
							req.clr = 1'b1;
							idx_n   = '0;
							state_n = ST_SREAD;
						end
						default: begin
							idx_n   = '0;
							state_n = ST_SREAD;
						end
					endcase
				end
			end
			ST_EXEC: begin
				if (cmd_q == lmsrw_pkg::CMD_SET && !inside_q) begin
					state_n = ST_IDLE;
				end else if (out_free) begin
					out_load = 1'b1;
					ld_last  = 1'b1;
					state_n  = ST_IDLE;
					if (cmd_q == lmsrw_pkg::CMD_SET) begin
						req.wr_en = 1'b1;
						ld_wr     = 1'b1;
						ld_fs     = 1'b1;
						ld_data   = new_nib;
					end else begin
						ld_led = inside_q && ((rd_data & mask) != '0);
					end
				end
			end
			ST_SREAD: begin
				req.rd_en   = 1'b1;
				req.rd_addr = idx_q;
				state_n     = ST_SOUT;
			end
			ST_SOUT: begin
				if (out_free) begin
					out_load = 1'b1;
					ld_wr    = 1'b1;
					ld_fs    = (idx_q == '0);
					ld_addr  = idx_q;
					ld_data  = rd_data;
					ld_last  = stream_last;
					if (stream_last) begin
						state_n = ST_IDLE;
					end else begin
						idx_n   = idx_q + 1'b1;
						state_n = ST_SREAD;
					end
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Command and result payload registers.
	always_ff @(posedge clk) begin
		idx_q <= idx_n;
		if (in_acc) begin
			cmd_q    <= s_tuser;
			addr_q   <= in_addr;
			col_lo_q <= s_tdata[1:0];
			on_q     <= s_tdata[8];
			inside_q <= in_inside;
		end
		if (out_load) begin
			out_addr_q <= ld_addr;
			out_data_q <= ld_data;
			out_led_q  <= ld_led;
			out_wr_q   <= ld_wr;
			out_fs_q   <= ld_fs;
			out_last_q <= ld_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, out_led_q, out_data_q, out_addr_q};
	assign m_tuser  = {out_fs_q, out_wr_q};
	assign m_tlast  = out_last_q;

	// A result is never loaded over one that is still waiting.
	`LMSRW_ASSERT_IMPL(a_no_overwrite, out_load, out_free, "result register overwritten")
	// Clearing and writing the store never happen in the same cycle.
	`LMSRW_ASSERT_ALWAYS(a_clr_wr_excl, !(req.clr && req.wr_en), "store clear during write")
	// The store is only written while a set is being executed.
	`LMSRW_ASSERT_IMPL(a_wr_in_set, req.wr_en,
		(state_q == ST_EXEC && cmd_q == lmsrw_pkg::CMD_SET), "store write outside a set")

endmodule
